>>> hw/rtl/swerve_wheel_kinematics_assert.svh
// Assertion macros shared by the swerve wheel kinematics RTL
`ifndef SWERVE_WHEEL_KINEMATICS_ASSERT_SVH
`define SWERVE_WHEEL_KINEMATICS_ASSERT_SVH
`ifndef SYNTHESIS
`define SWK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("swerve wheel kinematics: same-cycle check failed");
`define SWK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("swerve wheel kinematics: next-cycle check failed");
`else
`define SWK_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SWK_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/swk_pkg.sv
// Types, widths, constants and the arctangent table of the swerve wheel kinematics block
package swk_pkg;

    localparam int STICK_W       = 11;
    localparam int SWITCH_W      = 2;
    localparam int VEL_W         = STICK_W + 3;     // stick scaled by 8
    localparam int K_FRAC        = 15;
    localparam int KW_W          = 29;
    localparam int VEC_W         = 30;              // wheel vector component, Q15
    localparam int SQ_W          = 2 * VEC_W - 2;
    localparam int ROOT_W        = 30;
    localparam int RAD_W         = 2 * ROOT_W;
    localparam int ISQ_LAT       = ROOT_W + 2;
    localparam int CX_W          = 32;
    localparam int ANG_W         = 21;
    localparam int SCALE_W       = 26;
    localparam int PROD_W        = ANG_W + SCALE_W + 1;
    localparam int STEER_FRAC    = 24;
    localparam int STEER_W       = 20;
    localparam int SPEED_W       = 15;
    localparam int WHEEL_W       = 2;
    localparam int WHEEL_COUNT   = 4;
    localparam int CORDIC_STAGES = 16;

    localparam logic [SWITCH_W-1:0] SW_NORMAL  = 2'd3;
    localparam logic [WHEEL_W-1:0]  LAST_WHEEL = WHEEL_W'(WHEEL_COUNT - 1);
    localparam logic [15:0]         K_Q15      = 16'd23170;
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 26'd40248003;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 21'sd411775;

    // bit k set: the turn term enters wheel k's component with a minus sign
    localparam logic [WHEEL_COUNT-1:0] NEG_X_MASK = 4'b1001;
    localparam logic [WHEEL_COUNT-1:0] NEG_Y_MASK = 4'b0011;

    typedef struct packed {
        logic [WHEEL_W-1:0] wheel;
        logic               idle;
    } tag_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0:       a = 21'sd51472;
            1:       a = 21'sd30386;
            2:       a = 21'sd16055;
            3:       a = 21'sd8150;
            4:       a = 21'sd4091;
            5:       a = 21'sd2047;
            6:       a = 21'sd1024;
            7:       a = 21'sd512;
            8:       a = 21'sd256;
            9:       a = 21'sd128;
            10:      a = 21'sd64;
            11:      a = 21'sd32;
            12:      a = 21'sd16;
            13:      a = 21'sd8;
            14:      a = 21'sd4;
            15:      a = 21'sd2;
            16:      a = 21'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/swk_isqrt.sv
// Pipelined wheel speed magnitude: squares, sum and one root bit per stage
module swk_isqrt (
    input  logic                                aclk,
    input  logic                                adv,
    input  logic signed [swk_pkg::VEC_W-1:0]    vx,
    input  logic signed [swk_pkg::VEC_W-1:0]    vy,
    output logic [swk_pkg::ROOT_W-1:0]          root
);

    localparam int RW    = swk_pkg::ROOT_W;
    localparam int REM_W = RW + 2;
    localparam int RAD_W = swk_pkg::RAD_W;
    localparam int SQ_W  = swk_pkg::SQ_W;
    localparam int PW    = 2 * swk_pkg::VEC_W;

    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;
    logic [SQ_W:0]        sum;

    logic [RAD_W-1:0] rad_reg [0:RW];
    logic [REM_W-1:0] rem_reg [0:RW];
    logic [RW-1:0]    q_reg   [0:RW];

    logic [REM_W:0] acc   [0:RW-1];
    logic [REM_W:0] trial [0:RW-1];
    logic [REM_W:0] diff  [0:RW-1];
    logic           ge    [0:RW-1];

    assign px  = vx * vx;
    assign py  = vy * vy;
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_comb begin
        for (int i = 0; i < RW; i++) begin
            acc[i]   = {rem_reg[i][REM_W-2:0], rad_reg[i][RAD_W-1 -: 2]};
            trial[i] = {1'b0, q_reg[i], 2'b01};
            diff[i]  = acc[i] - trial[i];
            ge[i]    = (acc[i] >= trial[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg    <= px[SQ_W-1:0];
            sqy_reg    <= py[SQ_W-1:0];
            rad_reg[0] <= {{(RAD_W-SQ_W-1){1'b0}}, sum};
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            for (int i = 0; i < RW; i++) begin
                rad_reg[i+1] <= {rad_reg[i][RAD_W-3:0], 2'b00};
                rem_reg[i+1] <= ge[i] ? diff[i][REM_W-1:0] : acc[i][REM_W-1:0];
                q_reg[i+1]   <= {q_reg[i][RW-2:0], ge[i]};
            end
        end
    end

    assign root = q_reg[RW];

endmodule

>>> hw/rtl/swk_cordic.sv
// Pipelined vectoring CORDIC giving the wheel vector angle in Q16 radians
module swk_cordic #(
    parameter int STAGES = swk_pkg::CORDIC_STAGES
) (
    input  logic                                aclk,
    input  logic                                adv,
    input  logic signed [swk_pkg::VEC_W-1:0]    vx,
    input  logic signed [swk_pkg::VEC_W-1:0]    vy,
    output logic signed [swk_pkg::ANG_W-1:0]    angle
);

    localparam int CX_W  = swk_pkg::CX_W;
    localparam int VEC_W = swk_pkg::VEC_W;

    logic signed [CX_W-1:0]           vx_ext;
    logic signed [CX_W-1:0]           vy_ext;
    logic signed [CX_W-1:0]           x_reg [0:STAGES];
    logic signed [CX_W-1:0]           y_reg [0:STAGES];
    logic signed [swk_pkg::ANG_W-1:0] z_reg [0:STAGES];

    assign vx_ext = {{(CX_W-VEC_W){vx[VEC_W-1]}}, vx};
    assign vy_ext = {{(CX_W-VEC_W){vy[VEC_W-1]}}, vy};

    always_ff @(posedge aclk) begin
        if (adv) begin
            // fold the left half plane onto the right, start at +/- pi
            if (vx[VEC_W-1]) begin
                x_reg[0] <= -vx_ext;
                y_reg[0] <= -vy_ext;
                z_reg[0] <= vy[VEC_W-1] ? -swk_pkg::PI_Q16 : swk_pkg::PI_Q16;
            end else begin
                x_reg[0] <= vx_ext;
                y_reg[0] <= vy_ext;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < STAGES; i++) begin
                if (!y_reg[i][CX_W-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + swk_pkg::atan_q16(unsigned'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - swk_pkg::atan_q16(unsigned'(i));
                end
            end
        end
    end

    assign angle = z_reg[STAGES];

endmodule

>>> hw/rtl/swerve_wheel_kinematics.sv
// Swerve drive inverse kinematics top level: command in, four wheel targets out.
// Wheel results leave in wheel order, their delay set by the one-root-bit-per-stage
// speed pipeline. One wheel a cycle through the shared speed/angle pipeline while
// the output is not stalled, so a normal-mode command is held until its four
// wheels have issued; commands in other modes are dropped at the transfer.
// Reset clears all valid bits, the command holder's valid flag and wheel count, and loads the scale_reg default.
`include "swerve_wheel_kinematics_assert.svh"
module swerve_wheel_kinematics #(
    parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swk_pkg::SCALE_W-1:0]         cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [swk_pkg::SWITCH_W-1:0]        s_switch_left,
    input  logic [swk_pkg::SWITCH_W-1:0]        s_switch_right,
    input  logic signed [swk_pkg::STICK_W-1:0]  s_stick_x,
    input  logic signed [swk_pkg::STICK_W-1:0]  s_stick_y,
    input  logic signed [swk_pkg::STICK_W-1:0]  s_stick_turn,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swk_pkg::WHEEL_W-1:0]         m_wheel_index,
    output logic [swk_pkg::SPEED_W-1:0]         m_wheel_speed,
    output logic signed [swk_pkg::STEER_W-1:0]  m_steer_target,
    output logic                                m_last_wheel
);

    localparam int VEL_W     = swk_pkg::VEL_W;
    localparam int VEC_W     = swk_pkg::VEC_W;
    localparam int KW_W      = swk_pkg::KW_W;
    localparam int KW_FULL_W = VEL_W + 17;
    localparam int ANG_W     = swk_pkg::ANG_W;
    localparam int PROD_W    = swk_pkg::PROD_W;
    localparam int SH_W      = PROD_W - swk_pkg::STEER_FRAC;
    localparam int STEER_W   = swk_pkg::STEER_W;
    localparam int SPEED_W   = swk_pkg::SPEED_W;
    localparam int ROOT_W    = swk_pkg::ROOT_W;
    localparam int OUT_LVL   = swk_pkg::ISQ_LAT;
    localparam int STEER_DLY = OUT_LVL - CORDIC_STAGES - 4;

    localparam logic signed [PROD_W-1:0] STEER_HALF =
        PROD_W'(1) <<< (swk_pkg::STEER_FRAC - 1);
    localparam logic [ROOT_W:0] SPEED_HALF = (ROOT_W+1)'(1) << (SPEED_W - 1);

    // configuration
    logic [swk_pkg::SCALE_W-1:0] scale_reg;

    // command holder
    logic                           cmd_vld_reg, cmd_vld_next;
    logic [swk_pkg::WHEEL_W-1:0]    cnt_reg, cnt_next;
    logic signed [VEL_W-1:0]        cmd_x_reg, cmd_y_reg, cmd_w_reg;
    logic                           cmd_idle_reg;
    logic                           adv, issue, last_issue, s_fire, normal;

    // front stages
    logic signed [KW_FULL_W-1:0]    kw_full;
    logic                           p1_vld_reg;
    logic signed [VEL_W-1:0]        p1_x_reg, p1_y_reg;
    logic signed [KW_W-1:0]         p1_kw_reg;
    swk_pkg::tag_t                  p1_tag_reg;
    logic signed [VEC_W-1:0]        xs, ys, kws, vx_next, vy_next;
    logic                           p2_vld_reg;
    logic signed [VEC_W-1:0]        p2_vx_reg, p2_vy_reg;
    swk_pkg::tag_t                  p2_tag_reg;

    // tag and valid chain alongside the arithmetic
    logic                           vld_reg [1:OUT_LVL];
    swk_pkg::tag_t                  tag_reg [1:OUT_LVL];

    // angle path
    logic signed [ANG_W-1:0]        angle;
    logic signed [ANG_W-1:0]        e_raw, e_next, e_reg;
    logic signed [PROD_W-1:0]       prod, prod_reg, prod_rnd;
    logic signed [SH_W-1:0]         steer_sh;
    logic signed [STEER_W-1:0]      steer_next, steer_reg;
    logic signed [STEER_W-1:0]      dly_reg [1:STEER_DLY];

    // speed path
    logic [ROOT_W-1:0]              root;
    logic [ROOT_W:0]                root_rnd;
    logic [SPEED_W:0]               speed_full;
    logic [SPEED_W-1:0]             speed_sat;

    // output register
    logic                           m_valid_reg;
    logic [swk_pkg::WHEEL_W-1:0]    m_wheel_index_reg;
    logic [SPEED_W-1:0]             m_wheel_speed_reg;
    logic signed [STEER_W-1:0]      m_steer_target_reg;
    logic                           m_last_wheel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= swk_pkg::SCALE_RESET;
        end else if (cfg_valid) begin
            scale_reg <= cfg_data;
        end
    end

    // whole pipeline moves together; hold everything while the result waits
    assign adv        = !m_valid_reg || m_ready;
    assign issue      = cmd_vld_reg && adv;
    assign last_issue = issue && (cnt_reg == swk_pkg::LAST_WHEEL);
    assign s_ready    = !cmd_vld_reg || last_issue;
    assign s_fire     = s_valid && s_ready;
    assign normal     = (s_switch_left == swk_pkg::SW_NORMAL) &&
                        (s_switch_right == swk_pkg::SW_NORMAL);

    always_comb begin
        cmd_vld_next = cmd_vld_reg;
        cnt_next     = cnt_reg;
        if (issue) begin
            cnt_next = cnt_reg + swk_pkg::WHEEL_W'(1);
        end
        if (last_issue) begin
            cmd_vld_next = 1'b0;
        end
        // drop commands outside normal mode at the transfer
        if (s_fire) begin
            cmd_vld_next = normal;
            cnt_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            cmd_vld_reg <= cmd_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_x_reg    <= {s_stick_x, 3'b000};
            cmd_y_reg    <= {s_stick_y, 3'b000};
            cmd_w_reg    <= {s_stick_turn, 3'b000};
            cmd_idle_reg <= (s_stick_x == '0) && (s_stick_y == '0) && (s_stick_turn == '0);
        end
    end

    // stage 1: turn term k*w in Q15
    assign kw_full = cmd_w_reg * $signed({1'b0, swk_pkg::K_Q15});

    // stage 2: wheel vector components
    assign xs  = {{(VEC_W-VEL_W-swk_pkg::K_FRAC){p1_x_reg[VEL_W-1]}}, p1_x_reg,
                  {swk_pkg::K_FRAC{1'b0}}};
    assign ys  = {{(VEC_W-VEL_W-swk_pkg::K_FRAC){p1_y_reg[VEL_W-1]}}, p1_y_reg,
                  {swk_pkg::K_FRAC{1'b0}}};
    assign kws = {{(VEC_W-KW_W){p1_kw_reg[KW_W-1]}}, p1_kw_reg};
    assign vx_next = swk_pkg::NEG_X_MASK[p1_tag_reg.wheel] ? xs - kws : xs + kws;
    assign vy_next = swk_pkg::NEG_Y_MASK[p1_tag_reg.wheel] ? ys - kws : ys + kws;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            for (int i = 1; i <= OUT_LVL; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= cmd_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            vld_reg[1] <= p2_vld_reg;
            for (int i = 2; i <= OUT_LVL; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[OUT_LVL];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_x_reg         <= cmd_x_reg;
            p1_y_reg         <= cmd_y_reg;
            p1_kw_reg        <= kw_full[KW_W-1:0];
            p1_tag_reg.wheel <= cnt_reg;
            p1_tag_reg.idle  <= cmd_idle_reg;
            p2_vx_reg        <= vx_next;
            p2_vy_reg        <= vy_next;
            p2_tag_reg       <= p1_tag_reg;
            tag_reg[1]       <= p2_tag_reg;
            for (int i = 2; i <= OUT_LVL; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    swk_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk  (aclk),
        .adv   (adv),
        .vx    (p2_vx_reg),
        .vy    (p2_vy_reg),
        .angle (angle)
    );

    swk_isqrt u_isqrt (
        .aclk (aclk),
        .adv  (adv),
        .vx   (p2_vx_reg),
        .vy   (p2_vy_reg),
        .root (root)
    );

    // rotate by -pi/2 and wrap back into [-pi, pi]
    assign e_raw  = angle - swk_pkg::HALF_PI_Q16;
    assign e_next = (e_raw < -swk_pkg::PI_Q16) ? e_raw + swk_pkg::TWO_PI_Q16 : e_raw;

    assign prod     = e_reg * $signed({1'b0, scale_reg});
    assign prod_rnd = prod_reg + STEER_HALF;
    assign steer_sh = prod_rnd[PROD_W-1:swk_pkg::STEER_FRAC];

    always_comb begin
        if (!steer_sh[SH_W-1] && (|steer_sh[SH_W-2:STEER_W-1])) begin
            steer_next = {1'b0, {(STEER_W-1){1'b1}}};
        end else if (steer_sh[SH_W-1] && !(&steer_sh[SH_W-2:STEER_W-1])) begin
            steer_next = {1'b1, {(STEER_W-1){1'b0}}};
        end else begin
            steer_next = steer_sh[STEER_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg      <= e_next;
            prod_reg   <= prod;
            steer_reg  <= steer_next;
            dly_reg[1] <= steer_reg;
            for (int i = 2; i <= STEER_DLY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    // round the root to whole speed units, saturate
    assign root_rnd   = {1'b0, root} + SPEED_HALF;
    assign speed_full = root_rnd[ROOT_W:SPEED_W];
    assign speed_sat  = speed_full[SPEED_W] ? {SPEED_W{1'b1}} : speed_full[SPEED_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_wheel_index_reg  <= tag_reg[OUT_LVL].wheel;
            m_last_wheel_reg   <= (tag_reg[OUT_LVL].wheel == swk_pkg::LAST_WHEEL);
            m_wheel_speed_reg  <= tag_reg[OUT_LVL].idle ? '0 : speed_sat;
            m_steer_target_reg <= tag_reg[OUT_LVL].idle ? '0 : dly_reg[STEER_DLY];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_wheel_index  = m_wheel_index_reg;
    assign m_wheel_speed  = m_wheel_speed_reg;
    assign m_steer_target = m_steer_target_reg;
    assign m_last_wheel   = m_last_wheel_reg;

    `SWK_ASSERT_IMP(a_busy_blocks_input, aclk, aresetn, cmd_vld_reg && (cnt_reg != swk_pkg::LAST_WHEEL), !s_ready)
    `SWK_ASSERT_NXT(a_wheel_steps, aclk, aresetn, issue && !last_issue, cmd_vld_reg && (cnt_reg == $past(cnt_reg) + swk_pkg::WHEEL_W'(1)))
    `SWK_ASSERT_NXT(a_drop_other_mode, aclk, aresetn, s_fire && !normal, !cmd_vld_reg)
    `SWK_ASSERT_NXT(a_out_follows_chain, aclk, aresetn, adv, m_valid_reg == $past(vld_reg[OUT_LVL]))

endmodule
